// ===== hw/rtl/sosc_pkg.sv =====
// sosc_pkg: shared constants, types and the quarter-wave sine table for the
// sine oscillator. No dependencies; every other file of the block uses it.
package sosc_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int SAMPLE_BITS     = 16;

    localparam int STEP_W = 32;    // phase_step field
    localparam int AMP_W  = 16;    // amplitude field
    localparam int OUT_W  = 16;    // sample field
    localparam int IN_TDATA_W  = ((STEP_W + AMP_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam int TBL_N  = 1 << TABLE_ADDR_BITS;
    localparam int ADDR_W = TABLE_ADDR_BITS + 1;   // 0 .. TBL_N inclusive

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint SINE_FS = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;

    // (2n)(2n+1) divisors of the Taylor series, n = 1..7
    localparam longint unsigned SERIES_DIV [1:7] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
    };

    typedef logic signed [SAMPLE_BITS-1:0] t_sine;
    typedef t_sine t_quarter [TBL_N+1];

    // one queued item: table address, sign of the quadrant, gain
    typedef struct packed {
        logic [ADDR_W-1:0]       addr;
        logic                    neg;
        logic signed [AMP_W-1:0] amp;
    } t_cmd;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } t_q_stat;

    // sine of x (Q2.30 radians) in Q2.30, truncating series, clamped to [0,1]
    function automatic longint sine_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / SERIES_DIV[n];
            if (n % 2 == 1) sum = sum - longint'(term);
            else            sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
        return sum;
    endfunction

    function automatic t_quarter build_quarter();
        t_quarter        tbl;
        longint unsigned x;
        longint          s;
        for (int k = 0; k <= TBL_N; k++) begin
            x      = (longint'(k) * HALF_PI_Q30) >> TABLE_ADDR_BITS;
            s      = sine_q30(x);
            tbl[k] = SAMPLE_BITS'((s * SINE_FS + (64'sd1 <<< 29)) >>> 30);
        end
        return tbl;
    endfunction

    localparam t_quarter QUARTER = build_quarter();

endpackage

// ===== hw/rtl/sine_oscillator_top.sv =====
// sine_oscillator_top: phase-accumulator sine oscillator, top level.
// Depends on sosc_pkg, sosc_front, sosc_queue and sosc_back.
//
// Usage
//   Slave stream (i_s_*): one transaction per output sample, carrying a
//   signed phase step and a signed Q1.15 amplitude. The step is added to a
//   wrapping phase accumulator; the sine of the new phase is read from a
//   quarter-wave table, scaled by the amplitude, rounded half up and
//   saturated to Q1.15.
//   Master stream (o_m_*): one sample per accepted input, in order.
//   Throughput: one transaction per cycle, sustained, while the master side
//   keeps i_m_tready high.
//   Path: an accepted input passes the queue, the registered table read,
//   the multiply and the round/saturate stage before o_m_tvalid shows it.
//   The registered table read and the single multiplier set the pipe depth.
//   Stall: if the receiver holds i_m_tready low, the back pipe freezes with
//   its sample held; the front keeps filling a 4-entry queue and drops
//   o_s_tready only when that queue is full.
//   Reset (i_rst_n low, synchronous): phase accumulator cleared to zero,
//   queue emptied, pipe valids cleared. The sine table is constant and
//   needs no clearing.
module sine_oscillator_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // [31:0] phase_step, [47:32] amplitude
    input  logic [sosc_pkg::IN_TDATA_W-1:0]       i_s_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // [15:0] sample
    output logic [sosc_pkg::OUT_TDATA_W-1:0]      o_m_tdata
);

    localparam int SW = sosc_pkg::STEP_W;
    localparam int AW = sosc_pkg::AMP_W;

    logic                               push;
    logic                               pop;
    logic                               q_valid;
    sosc_pkg::t_cmd                     push_cmd;
    sosc_pkg::t_cmd                     pop_cmd;
    sosc_pkg::t_q_stat                  q_stat;
    logic signed [sosc_pkg::OUT_W-1:0]  sample;

    sosc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_step   (i_s_tdata[SW-1:0]),
        .i_amp    (i_s_tdata[SW+AW-1:SW]),
        .i_q_full (q_stat.full),
        .o_ready  (o_s_tready),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    sosc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_valid  (q_valid),
        .o_cmd    (pop_cmd),
        .o_stat   (q_stat)
    );

    sosc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (pop_cmd),
        .o_pop     (pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_sample  (sample)
    );

    assign o_m_tdata = {{(sosc_pkg::OUT_TDATA_W - sosc_pkg::OUT_W){1'b0}}, sample};

    // queue status is never both full and empty
    a_q_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty");

    // queue fill goes up by one after a push with no pop beside it
    a_q_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !(pop && q_valid)) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
        else $error("queue count did not follow a push");

    // an empty queue with no push keeps its count at zero
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_stat.empty && !push) |=> (q_stat.count == '0))
        else $error("queue count moved while empty and idle");

    // no sample is presented right after reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

// ===== hw/rtl/sosc_front.sv =====
// sosc_front: phase accumulator and quadrant decode; turns each accepted
// transaction into a table command for the queue. Uses sosc_pkg.
module sosc_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic signed [sosc_pkg::STEP_W-1:0]   i_step,
    input  logic signed [sosc_pkg::AMP_W-1:0]    i_amp,
    input  logic                                 i_q_full,
    output logic                                 o_ready,
    output logic                                 o_push,
    output sosc_pkg::t_cmd                       o_cmd
);

    localparam int PB = sosc_pkg::PHASE_BITS;
    localparam int A  = sosc_pkg::TABLE_ADDR_BITS;

    logic [PB-1:0] r_phase;
    logic [PB-1:0] n_phase;
    logic [63:0]   step_ext;
    logic [1:0]    quad;
    logic [A-1:0]  idx;

    assign o_ready  = !i_q_full;
    assign o_push   = i_valid && o_ready;
    assign step_ext = {{(64 - sosc_pkg::STEP_W){i_step[sosc_pkg::STEP_W-1]}}, i_step};
    assign n_phase  = r_phase + step_ext[PB-1:0];
    assign quad     = n_phase[PB-1 -: 2];
    assign idx      = n_phase[PB-3 -: A];

    always_comb begin
        o_cmd.neg = quad[1];
        o_cmd.amp = i_amp;
        if (quad[0]) o_cmd.addr = sosc_pkg::ADDR_W'(sosc_pkg::TBL_N) - {1'b0, idx};
        else         o_cmd.addr = {1'b0, idx};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (o_push) begin
            r_phase <= n_phase;
        end
    end

endmodule

// ===== hw/rtl/sosc_queue.sv =====
// sosc_queue: short FIFO of table commands between front and back.
// Uses sosc_pkg for depth and the command type.
module sosc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sosc_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output logic                o_valid,
    output sosc_pkg::t_cmd      o_cmd,
    output sosc_pkg::t_q_stat   o_stat
);

    sosc_pkg::t_cmd                 r_mem [sosc_pkg::Q_DEPTH];
    logic [sosc_pkg::Q_PTR_W-1:0]   r_wr_ptr;
    logic [sosc_pkg::Q_PTR_W-1:0]   r_rd_ptr;
    logic [sosc_pkg::Q_CNT_W-1:0]   r_count;
    logic                           do_pop;

    assign do_pop       = i_pop && (r_count != '0);
    assign o_valid      = (r_count != '0);
    assign o_cmd        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == sosc_pkg::Q_CNT_W'(sosc_pkg::Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop) r_rd_ptr <= r_rd_ptr + 1'b1;
            unique case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/sosc_back.sv =====
// sosc_back: table read, gain multiply, round and saturate, output register.
// Uses sosc_pkg for the sine table, widths and command type.
module sosc_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  sosc_pkg::t_cmd                    i_cmd,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [sosc_pkg::OUT_W-1:0] o_sample
);

    localparam int SB     = sosc_pkg::SAMPLE_BITS;
    localparam int PROD_W = SB + sosc_pkg::AMP_W;
    localparam longint SAT_MAX = (64'sd1 <<< (sosc_pkg::OUT_W - 1)) - 64'sd1;
    localparam longint SAT_MIN = -(64'sd1 <<< (sosc_pkg::OUT_W - 1));

    logic                                 en;
    logic                                 r_v1, r_v2, r_v3;
    sosc_pkg::t_sine                      r_tbl;
    logic                                 r_neg1;
    logic signed [sosc_pkg::AMP_W-1:0]    r_amp1;
    logic signed [PROD_W-1:0]             r_prod;
    logic signed [sosc_pkg::OUT_W-1:0]    r_out;
    sosc_pkg::t_sine                      sine;
    logic signed [PROD_W:0]               rnd;
    logic signed [PROD_W:0]               shf;
    logic signed [sosc_pkg::OUT_W-1:0]    n_out;

    // whole pipe advances unless the output holds an untaken sample
    assign en       = !r_v3 || i_ready;
    assign o_pop    = i_q_valid && en;
    assign o_valid  = r_v3;
    assign o_sample = r_out;

    assign sine = r_neg1 ? -r_tbl : r_tbl;
    assign rnd  = {r_prod[PROD_W-1], r_prod} + (PROD_W + 1)'(64'sd1 <<< (SB - 2));
    assign shf  = rnd >>> (SB - 1);

    always_comb begin
        if (shf > SAT_MAX)      n_out = sosc_pkg::OUT_W'(SAT_MAX);
        else if (shf < SAT_MIN) n_out = sosc_pkg::OUT_W'(SAT_MIN);
        else                    n_out = shf[sosc_pkg::OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tbl  <= sosc_pkg::QUARTER[i_cmd.addr];
            r_neg1 <= i_cmd.neg;
            r_amp1 <= i_cmd.amp;
            r_prod <= sine * r_amp1;
            r_out  <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

endmodule
